// ===== rtl/core/scp_pkg.sv =====
// Shared types and constants of the shortest-column placer.
package scp_pkg;

  localparam int unsigned MaxColumnsDef = 16;

  localparam int unsigned CountW   = 5;
  localparam int unsigned ColWidthW = 12;
  localparam int unsigned SpacingW = 8;
  localparam int unsigned MarginW  = 10;
  localparam int unsigned AreaW    = 13;
  localparam int unsigned AlignW   = 2;
  localparam int unsigned HeightW  = 12;
  localparam int unsigned XPosW    = 18;
  localparam int unsigned YPosW    = 20;
  localparam int unsigned ColumnW  = 4;
  localparam int unsigned BottomW  = 20;
  localparam int unsigned PitchW   = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam int XMax = 131071;
  localparam int XMin = -131072;

  localparam logic [CfgIdxW-1:0] CfgColumnCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgColumnWidth = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSpacingH    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSpacingV    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMarginH     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMarginV     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgAreaWidth   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgAlignMode   = 3'd7;

  localparam logic [AlignW-1:0] AlignDefault = 2'd0;
  localparam logic [AlignW-1:0] AlignLeft    = 2'd1;
  localparam logic [AlignW-1:0] AlignCenter  = 2'd2;
  localparam logic [AlignW-1:0] AlignRight   = 2'd3;

  localparam logic FuncRestart = 1'b0;
  localparam logic FuncPlace   = 1'b1;

  typedef struct packed {
    logic               func;
    logic [HeightW-1:0] item_height;
  } in_item_t;

  typedef struct packed {
    logic signed [XPosW-1:0] x_pos;
    logic [YPosW-1:0]        y_pos;
    logic [ColumnW-1:0]      column;
    logic [YPosW-1:0]        content_height;
  } out_item_t;

endpackage

// ===== rtl/core/shortest_column_placer_core.sv =====
// Shortest-column masonry placer: column bottoms in a RAM with a registered read.
//
// Input channel in_valid_i / in_stall_o carries one in_item_t per transfer.
// func = restart sets every column bottom to margin_v and recomputes the
// left origin from the alignment mode; func = place scans the columns in
// use for the lowest bottom (lowest index on ties) and stacks the item there.
// Each input transfer gives exactly one out_item_t on out_valid_o /
// out_stall_i.
// Restart goes from the transfer through the restart and final states to
// output valid; place reads the bottom RAM one column per cycle over the
// columns in use, then goes through the update and final states. A new item
// is taken only in idle, also while a result waits in the output register;
// a stalled result holds and blocks only the final stage. Reset clears all
// configuration to its defaults, the origin and the tallest bottom to zero,
// and marks every column as holding the restart base (zero); no clearing
// pass is needed. Configuration is written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must do so only while the block is idle (unenforced).
module shortest_column_placer_core import scp_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MaxColumnsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned NW   = CW + 1;
  localparam int unsigned CMPW = (NW > CountW) ? NW : CountW;
  localparam int unsigned PRW  = NW + PitchW;
  localparam int unsigned XW   = PRW + 2;
  localparam int unsigned SUMW = BottomW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RST  = 5'b00010,
    S_SCAN = 5'b00100,
    S_UPD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0]    cfg_count_q;
  logic [ColWidthW-1:0] cfg_colw_q;
  logic [SpacingW-1:0]  cfg_sph_q;
  logic [SpacingW-1:0]  cfg_spv_q;
  logic [MarginW-1:0]   cfg_mh_q;
  logic [MarginW-1:0]   cfg_mv_q;
  logic [AreaW-1:0]     cfg_area_q;
  logic [AlignW-1:0]    cfg_align_q;

  logic signed [XPosW-1:0] left_origin_q;
  logic [BottomW-1:0]      tallest_q;
  logic [BottomW-1:0]      base_q;
  logic [MAX_COLUMNS-1:0]  valid_q;
  logic                    out_valid_q;

  logic [BottomW-1:0] col_mem_q [MAX_COLUMNS];
  logic [BottomW-1:0] rdata_q;
  logic               rvalid_q;

  logic [HeightW-1:0]      height_q;
  logic [PRW-1:0]          prod_q;
  logic [CW-1:0]           cmp_idx_q;
  logic [CW-1:0]           best_q;
  logic [BottomW-1:0]      top_q;
  logic signed [XW-1:0]    x_acc_q;
  logic signed [XW-1:0]    best_x_q;
  out_item_t               res_q;
  out_item_t               out_q;

  logic                 in_xfer;
  logic                 rd_en;
  logic [CW-1:0]        rd_addr;
  logic [NW-1:0]        n_cols;
  logic [PitchW-1:0]    pitch;
  logic signed [XW-1:0] pitch_x;
  logic [BottomW-1:0]   cur_bot;
  logic                 take_cur;
  logic [NW-1:0]        nxt_idx;
  logic                 scan_more;
  logic [SUMW-1:0]      new_sum;
  logic [BottomW-1:0]   new_bot;
  logic [SUMW-1:0]      content_sum;
  logic                 out_load;

  logic signed [XW-1:0] aw_s, prod_s, sh_s, mh_s;
  logic signed [XW-1:0] diff, diff_adj, org;
  logic signed [XW-1:0] x_sat_src;
  logic signed [XPosW-1:0] org_sat, x_sat;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // columns in use, clamped to 1..MAX_COLUMNS
  always_comb begin
    if (cfg_count_q == '0) begin
      n_cols = NW'(1);
    end else if (CMPW'(cfg_count_q) > CMPW'(MAX_COLUMNS)) begin
      n_cols = NW'(MAX_COLUMNS);
    end else begin
      n_cols = NW'(cfg_count_q);
    end
  end

  assign pitch   = PitchW'(cfg_colw_q) + PitchW'(cfg_sph_q);
  assign pitch_x = $signed(XW'(pitch));

  assign cur_bot   = rvalid_q ? rdata_q : base_q;
  assign take_cur  = (cmp_idx_q == '0) || (cur_bot < top_q);
  assign nxt_idx   = NW'(cmp_idx_q) + NW'(1);
  assign scan_more = (nxt_idx < n_cols);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_q == S_IDLE && in_xfer && in_data_i.func == FuncPlace) begin
      rd_en = 1'b1;
    end else if (state_q == S_SCAN && scan_more) begin
      rd_en   = 1'b1;
      rd_addr = nxt_idx[CW-1:0];
    end
  end

  // restart origin
  always_comb begin
    aw_s     = $signed(XW'(cfg_area_q));
    prod_s   = $signed(XW'(prod_q));
    sh_s     = $signed(XW'(cfg_sph_q));
    mh_s     = $signed(XW'(cfg_mh_q));
    diff     = aw_s - prod_s;
    diff_adj = diff + $signed(XW'(diff[XW-1]));
    case (cfg_align_q)
      AlignCenter: org = (diff_adj >>> 1) + (sh_s >>> 1);
      AlignRight:  org = aw_s - $signed(XW'(1)) - mh_s - prod_s + sh_s;
      AlignDefault, AlignLeft: org = mh_s;
      default:     org = mh_s;
    endcase
    if (org > $signed(XW'(XMax))) begin
      org_sat = XPosW'(XMax);
    end else if (org < $signed(XW'(XMin))) begin
      org_sat = XPosW'(XMin);
    end else begin
      org_sat = org[XPosW-1:0];
    end
  end

  always_comb begin
    x_sat_src = best_x_q;
    if (x_sat_src > $signed(XW'(XMax))) begin
      x_sat = XPosW'(XMax);
    end else if (x_sat_src < $signed(XW'(XMin))) begin
      x_sat = XPosW'(XMin);
    end else begin
      x_sat = x_sat_src[XPosW-1:0];
    end
  end

  assign new_sum = SUMW'(top_q) + SUMW'(height_q) + SUMW'(cfg_spv_q);
  assign new_bot = new_sum[BottomW] ? {BottomW{1'b1}} : new_sum[BottomW-1:0];

  assign content_sum = SUMW'(tallest_q) + SUMW'(cfg_mv_q);
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (in_data_i.func == FuncRestart) ? S_RST : S_SCAN;
        end
      end
      S_RST:  state_d = S_FIN;
      S_SCAN: begin
        if (!scan_more) begin
          state_d = S_UPD;
        end
      end
      S_UPD:  state_d = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cfg_count_q   <= CountW'(1);
      cfg_colw_q    <= ColWidthW'(1);
      cfg_sph_q     <= '0;
      cfg_spv_q     <= '0;
      cfg_mh_q      <= '0;
      cfg_mv_q      <= '0;
      cfg_area_q    <= AreaW'(1);
      cfg_align_q   <= AlignDefault;
      left_origin_q <= '0;
      tallest_q     <= '0;
      base_q        <= '0;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgColumnCount: cfg_count_q <= cfg_wdata_i[CountW-1:0];
          CfgColumnWidth: cfg_colw_q  <= cfg_wdata_i[ColWidthW-1:0];
          CfgSpacingH:    cfg_sph_q   <= cfg_wdata_i[SpacingW-1:0];
          CfgSpacingV:    cfg_spv_q   <= cfg_wdata_i[SpacingW-1:0];
          CfgMarginH:     cfg_mh_q    <= cfg_wdata_i[MarginW-1:0];
          CfgMarginV:     cfg_mv_q    <= cfg_wdata_i[MarginW-1:0];
          CfgAreaWidth:   cfg_area_q  <= cfg_wdata_i[AreaW-1:0];
          CfgAlignMode:   cfg_align_q <= cfg_wdata_i[AlignW-1:0];
          default: ;
        endcase
      end
      if (state_q == S_RST) begin
        left_origin_q <= org_sat;
        tallest_q     <= BottomW'(cfg_mv_q);
        base_q        <= BottomW'(cfg_mv_q);
        valid_q       <= '0;
      end
      if (state_q == S_UPD) begin
        valid_q[best_q] <= 1'b1;
        if (new_bot > tallest_q) begin
          tallest_q <= new_bot;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // column bottom RAM, one read and one write port
  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      col_mem_q[best_q] <= new_bot;
    end
    if (rd_en) begin
      rdata_q  <= col_mem_q[rd_addr];
      rvalid_q <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      height_q  <= in_data_i.item_height;
      prod_q    <= PRW'(n_cols) * PRW'(pitch);
      cmp_idx_q <= '0;
      best_q    <= '0;
      x_acc_q   <= XW'(left_origin_q);
    end
    if (state_q == S_SCAN) begin
      if (take_cur) begin
        top_q    <= cur_bot;
        best_q   <= cmp_idx_q;
        best_x_q <= x_acc_q;
      end
      x_acc_q <= x_acc_q + pitch_x;
      if (scan_more) begin
        cmp_idx_q <= nxt_idx[CW-1:0];
      end
    end
    if (state_q == S_RST) begin
      res_q.x_pos          <= '0;
      res_q.y_pos          <= '0;
      res_q.column         <= '0;
      res_q.content_height <= '0;
    end
    if (state_q == S_UPD) begin
      res_q.x_pos  <= x_sat;
      res_q.y_pos  <= top_q;
      res_q.column <= ColumnW'(best_q);
    end
    if (out_load) begin
      out_q.x_pos          <= res_q.x_pos;
      out_q.y_pos          <= res_q.y_pos;
      out_q.column         <= res_q.column;
      out_q.content_height <= content_sum[BottomW] ? {YPosW{1'b1}}
                                                   : content_sum[BottomW-1:0];
    end
  end

  a_restart_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.func == FuncRestart |=> state_q == S_RST)
    else $error("restart transfer did not enter restart state");

  a_best_behind_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && cmp_idx_q != '0 |-> best_q < cmp_idx_q)
    else $error("best column ahead of scan position");

  a_tallest_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_RST |=> tallest_q >= $past(tallest_q))
    else $error("tallest bottom decreased outside restart");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FIN))
    else $error("result raised outside final stage");

endmodule
